// ----- rtl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on aclk.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define FST_ASSERT(label, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error("assertion failed");

// checked on every edge, reset included
`define FST_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge aclk) (prop)) \
        else $error("assertion failed");

`endif

// ----- rtl/fst_pkg.sv -----
// ---------------------------------------------------------------------------
// fst_pkg
// Shared constants and types of the frame sequence timer.
// ---------------------------------------------------------------------------
package fst_pkg;

    localparam int FRAME_COUNT = 16;
    localparam int MAX_HOPS    = 64;

    localparam int CMD_W   = 2;
    localparam int IDX_W   = 4;
    localparam int DUR_W   = 16;
    localparam int SUCC_W  = 5;
    localparam int LEFT_W  = DUR_W + 1;
    localparam int HOP_W   = $clog2(MAX_HOPS + 1);

    localparam int S_DATA_W = 48;
    localparam int M_DATA_W = 24;

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE   = 2'd0,
        CMD_ADVANCE = 2'd1,
        CMD_RESTART = 2'd2
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_HOP  = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

    typedef struct packed {
        logic accept;
        logic hop;
        logic set_hit;
        logic emit;
    } ctrl_t;

    typedef struct packed {
        logic is_advance;
        logic hop_active;
        logic hop_hit;
    } stat_t;

endpackage

// ----- rtl/fst_ctrl.sv -----
// ---------------------------------------------------------------------------
// fst_ctrl
// Sequencer: takes one transaction, steps frame hops, hands off the result.
// ---------------------------------------------------------------------------
module fst_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    output logic          m_tvalid,
    input  logic          m_tready,
    input  fst_pkg::stat_t stat,
    output fst_pkg::ctrl_t ctrl
);

    fst_pkg::state_t state_reg, state_next;
    logic            out_valid_reg, out_valid_next;
    logic            out_free;

    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == fst_pkg::ST_IDLE);
    assign m_tvalid = out_valid_reg;

    always_comb begin
        state_next   = state_reg;
        ctrl         = '0;
        ctrl.accept  = s_tvalid && s_tready;
        case (state_reg)
            fst_pkg::ST_IDLE: begin
                if (ctrl.accept) begin
                    state_next = stat.is_advance ? fst_pkg::ST_HOP : fst_pkg::ST_EMIT;
                end
            end
            fst_pkg::ST_HOP: begin
                ctrl.hop     = stat.hop_active;
                ctrl.set_hit = stat.hop_hit;
                if (!stat.hop_active) begin
                    state_next = fst_pkg::ST_EMIT;
                end
            end
            fst_pkg::ST_EMIT: begin
                if (out_free) begin
                    ctrl.emit  = 1'b1;
                    state_next = fst_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = fst_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (ctrl.emit) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= fst_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ----- rtl/fst_datapath.sv -----
// ---------------------------------------------------------------------------
// fst_datapath
// Frame table, current frame, signed time left, hop count, result register.
// ---------------------------------------------------------------------------
module fst_datapath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  fst_pkg::ctrl_t                ctrl,
    output fst_pkg::stat_t                stat,
    input  logic [fst_pkg::CMD_W-1:0]     s_command,
    input  logic [fst_pkg::IDX_W-1:0]     s_entry_index,
    input  logic [fst_pkg::DUR_W-1:0]     s_entry_ticks,
    input  logic signed [fst_pkg::SUCC_W-1:0] s_entry_next,
    input  logic [fst_pkg::DUR_W-1:0]     s_tick_count,
    output logic [fst_pkg::IDX_W-1:0]     m_current_frame,
    output logic [fst_pkg::DUR_W-1:0]     m_remaining_ticks,
    output logic                          m_hop_limit_hit
);

    logic [fst_pkg::DUR_W-1:0]  dur_mem  [fst_pkg::FRAME_COUNT];
    logic [fst_pkg::SUCC_W-1:0] succ_mem [fst_pkg::FRAME_COUNT];

    logic [fst_pkg::IDX_W-1:0]         cur_idx_reg, cur_idx_next;
    logic signed [fst_pkg::LEFT_W-1:0] left_reg, left_next;
    logic [fst_pkg::HOP_W-1:0]         hops_reg, hops_next;
    logic                              hit_reg, hit_next;

    logic [fst_pkg::IDX_W-1:0]  out_frame_reg;
    logic [fst_pkg::DUR_W-1:0]  out_rem_reg;
    logic                       out_hit_reg;

    logic [fst_pkg::SUCC_W-1:0] succ_raw;
    logic                       has_succ;
    logic [fst_pkg::IDX_W-1:0]  next_idx;
    logic                       hop_due;
    logic                       hops_left;
    logic [fst_pkg::DUR_W-1:0]  left_clamped;
    fst_pkg::cmd_t              cmd;

    assign cmd          = fst_pkg::cmd_t'(s_command);
    assign succ_raw     = succ_mem[cur_idx_reg];
    assign has_succ     = !succ_raw[fst_pkg::SUCC_W-1]
                          && (32'(succ_raw[fst_pkg::SUCC_W-2:0]) < fst_pkg::FRAME_COUNT);
    assign next_idx     = succ_raw[fst_pkg::IDX_W-1:0];
    assign hop_due      = (left_reg <= 0) && has_succ;
    assign hops_left    = (32'(hops_reg) < fst_pkg::MAX_HOPS);
    assign left_clamped = left_reg[fst_pkg::LEFT_W-1] ? '0 : left_reg[fst_pkg::DUR_W-1:0];

    assign stat.is_advance = (cmd == fst_pkg::CMD_ADVANCE);
    assign stat.hop_active = hop_due && hops_left;
    assign stat.hop_hit    = hop_due && !hops_left;

    always_ff @(posedge aclk) begin
        if (ctrl.accept && (cmd == fst_pkg::CMD_WRITE)
                && (32'(s_entry_index) < fst_pkg::FRAME_COUNT)) begin
            dur_mem[s_entry_index]  <= s_entry_ticks;
            succ_mem[s_entry_index] <= s_entry_next;
        end
    end

    always_comb begin
        cur_idx_next = cur_idx_reg;
        left_next    = left_reg;
        hops_next    = hops_reg;
        hit_next     = hit_reg;
        if (ctrl.accept) begin
            hops_next = '0;
            hit_next  = 1'b0;
            case (cmd)
                fst_pkg::CMD_ADVANCE: begin
                    left_next = left_reg - $signed({1'b0, s_tick_count});
                end
                fst_pkg::CMD_RESTART: begin
                    cur_idx_next = '0;
                    left_next    = $signed({1'b0, dur_mem[0]});
                end
                default: begin
                end
            endcase
        end else if (ctrl.hop) begin
            cur_idx_next = next_idx;
            hops_next    = hops_reg + 1'b1;
            left_next    = left_reg + $signed({1'b0, dur_mem[next_idx]});
        end else if (ctrl.set_hit) begin
            hit_next = 1'b1;
        end else if (ctrl.emit) begin
            left_next = $signed({1'b0, left_clamped});
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_idx_reg <= '0;
            left_reg    <= '0;
            hops_reg    <= '0;
            hit_reg     <= 1'b0;
        end else begin
            cur_idx_reg <= cur_idx_next;
            left_reg    <= left_next;
            hops_reg    <= hops_next;
            hit_reg     <= hit_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.emit) begin
            out_frame_reg <= cur_idx_reg;
            out_rem_reg   <= left_clamped;
            out_hit_reg   <= hit_reg;
        end
    end

    assign m_current_frame   = out_frame_reg;
    assign m_remaining_ticks = out_rem_reg;
    assign m_hop_limit_hit   = out_hit_reg;

endmodule

// ----- rtl/frame_sequence_timer.sv -----
// ---------------------------------------------------------------------------
// frame_sequence_timer
// Animation frame sequencer: frame table, tick countdown, successor hops.
// ---------------------------------------------------------------------------
//  channel   dir  tdata bits  contents
//  s_axis    in   48          command, entry_index, entry_ticks, entry_next,
//                             tick_count
//  m_axis    out  24          current_frame, remaining_ticks, hop_limit_hit
//
//  One transaction in flight. Write, restart and unused commands go from idle
//  straight to the emit state; an advance steps through the hop state first
//  (one hop per cycle, at most 64 hops), one table lookup and add per hop.
//  A result held in the output register does not block the next input.
//  Synchronous active-low reset; the frame table is not cleared.
// ---------------------------------------------------------------------------
module frame_sequence_timer (
    input  logic                            aclk,
    input  logic                            aresetn,
    // [1:0] command, [5:2] entry_index, [21:6] entry_ticks,
    // [26:22] entry_next, [42:27] tick_count, [47:43] zero
    input  logic [fst_pkg::S_DATA_W-1:0]    s_tdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [3:0] current_frame, [19:4] remaining_ticks, [20] hop_limit_hit,
    // [23:21] zero
    output logic [fst_pkg::M_DATA_W-1:0]    m_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready
);

    fst_pkg::ctrl_t ctrl;
    fst_pkg::stat_t stat;

    logic [fst_pkg::IDX_W-1:0] current_frame;
    logic [fst_pkg::DUR_W-1:0] remaining_ticks;
    logic                      hop_limit_hit;

    fst_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .ctrl     (ctrl)
    );

    fst_datapath u_datapath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .ctrl              (ctrl),
        .stat              (stat),
        .s_command         (s_tdata[1:0]),
        .s_entry_index     (s_tdata[5:2]),
        .s_entry_ticks     (s_tdata[21:6]),
        .s_entry_next      (s_tdata[26:22]),
        .s_tick_count      (s_tdata[42:27]),
        .m_current_frame   (current_frame),
        .m_remaining_ticks (remaining_ticks),
        .m_hop_limit_hit   (hop_limit_hit)
    );

    assign m_tdata = {3'b000, hop_limit_hit, remaining_ticks, current_frame};

endmodule

// ----- rtl/fst_checker.sv -----
// ---------------------------------------------------------------------------
// fst_checker
// Port-level checks on the frame sequence timer, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module fst_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic [fst_pkg::S_DATA_W-1:0] s_tdata,
    input logic                         s_tvalid,
    input logic                         s_tready,
    input logic [fst_pkg::M_DATA_W-1:0] m_tdata,
    input logic                         m_tvalid,
    input logic                         m_tready
);

    logic s_xfer;
    logic m_stall;

    assign s_xfer  = s_tvalid && s_tready && (s_tdata[0] || !s_tdata[0]);
    assign m_stall = m_tvalid && !m_tready;

    `FST_ASSERT_ALWAYS(a_reset_no_result, !aresetn |=> !m_tvalid)
    `FST_ASSERT(a_one_in_flight, s_xfer |=> !s_tready)
    `FST_ASSERT(a_hit_clamps_zero, (m_tvalid && m_tdata[20]) |-> (m_tdata[19:4] == 16'd0))
    `FST_ASSERT(a_stall_holds_valid, m_stall |=> m_tvalid)
    `FST_ASSERT(a_stall_holds_data, m_stall |=> $stable(m_tdata))

endmodule

bind frame_sequence_timer fst_checker u_fst_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tdata  (s_tdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);

// ----- bench/tb.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for frame_sequence_timer. Frame table writes, advances,
// restarts and the unused command are streamed in with random gaps and
// backpressure. A local model of the frame table and hop loop predicts each
// result, and every result is compared field by field.
// ---------------------------------------------------------------------------
module tb;

    localparam logic [fst_pkg::CMD_W-1:0]  CMD_UNUSED = 2'd3;
    localparam logic [fst_pkg::SUCC_W-1:0] NEXT_STOP  = 5'h1F;
    localparam int ITEM_TARGET = 1450;
    localparam int IDLE_LIMIT  = 2000;
    localparam int DRAIN_WAIT  = 100;

    typedef struct packed {
        logic [fst_pkg::IDX_W-1:0] frame;
        logic [fst_pkg::DUR_W-1:0] ticks_left;
        logic                      hit;
    } shown_t;

    logic                         aclk     = 1'b0;
    logic                         aresetn  = 1'b0;
    logic [fst_pkg::S_DATA_W-1:0] s_tdata  = '0;
    logic                         s_tvalid = 1'b0;
    logic                         s_tready;
    logic [fst_pkg::M_DATA_W-1:0] m_tdata;
    logic                         m_tvalid;
    logic                         m_tready = 1'b0;

    frame_sequence_timer u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // command queue and expected frame states
    logic [fst_pkg::S_DATA_W-1:0] cmd_queue [$];
    shown_t                       shown_q   [$];
    int                           mismatches = 0;

    // local copy of the sequencer
    logic [fst_pkg::DUR_W-1:0]  tbl_dur  [fst_pkg::FRAME_COUNT];
    logic [fst_pkg::SUCC_W-1:0] tbl_succ [fst_pkg::FRAME_COUNT];
    logic [fst_pkg::IDX_W-1:0]  shown_frame = '0;
    logic [fst_pkg::DUR_W-1:0]  time_left   = '0;

    function automatic void push_cmd(logic [fst_pkg::CMD_W-1:0] cmd,
                                     logic [fst_pkg::IDX_W-1:0] idx,
                                     logic [fst_pkg::DUR_W-1:0] dur,
                                     logic [fst_pkg::SUCC_W-1:0] nxt,
                                     logic [fst_pkg::DUR_W-1:0] cnt);
        cmd_queue.push_back({5'b0, cnt, nxt, dur, idx, cmd});
    endfunction

    function automatic void push_write(int idx, logic [fst_pkg::DUR_W-1:0] dur,
                                       logic [fst_pkg::SUCC_W-1:0] nxt);
        push_cmd(fst_pkg::CMD_WRITE, idx[fst_pkg::IDX_W-1:0], dur, nxt, 16'($urandom));
    endfunction

    function automatic void push_advance(logic [fst_pkg::DUR_W-1:0] cnt);
        push_cmd(fst_pkg::CMD_ADVANCE, 4'($urandom), 16'($urandom), 5'($urandom), cnt);
    endfunction

    function automatic void push_restart();
        push_cmd(fst_pkg::CMD_RESTART, 4'($urandom), 16'($urandom), 5'($urandom),
                 16'($urandom));
    endfunction

    function automatic logic [fst_pkg::DUR_W-1:0] draw_dur();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return '0;
        if (r < 20) return 16'($urandom);
        if (r < 25) return 16'hFFFF;
        return 16'($urandom_range(1, 40));
    endfunction

    function automatic logic [fst_pkg::SUCC_W-1:0] draw_next();
        if ($urandom_range(0, 4) == 0) return NEXT_STOP;
        return 5'($urandom_range(0, fst_pkg::FRAME_COUNT - 1));
    endfunction

    function automatic logic [fst_pkg::DUR_W-1:0] draw_ticks();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return '0;
        if (r < 20) return 16'($urandom);
        if (r < 23) return 16'hFFFF;
        return 16'($urandom_range(0, 80));
    endfunction

    // one command in, one frame state out
    function automatic void predict_frame_step(logic [fst_pkg::S_DATA_W-1:0] word);
        logic [fst_pkg::CMD_W-1:0]  cmd;
        logic [fst_pkg::SUCC_W-1:0] nxt;
        int                         left;
        int                         hops;
        logic                       hit;
        shown_t                     res;
        cmd  = word[1:0];
        hit  = 1'b0;
        hops = 0;
        case (cmd)
            fst_pkg::CMD_WRITE: begin
                tbl_dur[word[5:2]]  = word[21:6];
                tbl_succ[word[5:2]] = word[26:22];
            end
            fst_pkg::CMD_ADVANCE: begin
                left = int'(time_left) - int'(word[42:27]);
                while (left <= 0) begin
                    nxt = tbl_succ[shown_frame];
                    if (nxt[fst_pkg::SUCC_W-1] || int'(nxt) >= fst_pkg::FRAME_COUNT) break;
                    if (hops >= fst_pkg::MAX_HOPS) begin
                        hit = 1'b1;
                        break;
                    end
                    shown_frame = nxt[fst_pkg::IDX_W-1:0];
                    hops++;
                    left += int'(tbl_dur[shown_frame]);
                end
                time_left = (left < 0) ? '0 : left[fst_pkg::DUR_W-1:0];
            end
            fst_pkg::CMD_RESTART: begin
                shown_frame = '0;
                time_left   = tbl_dur[0];
            end
            default: ;
        endcase
        res.frame      = shown_frame;
        res.ticks_left = time_left;
        res.hit        = hit;
        shown_q.push_back(res);
    endfunction

    // stimulus
    initial begin : stimulus
        logic [fst_pkg::IDX_W-1:0] ring [6];
        int                        k;
        int                        r;
        // every entry is loaded before anything reads the table
        push_write(0, 16'd5, 5'd1);
        push_write(1, 16'd0, 5'd2);
        push_write(2, 16'hFFFF, 5'd3);
        push_write(3, 16'd1, NEXT_STOP);
        push_write(4, 16'd0, 5'd4);
        for (int i = 5; i < fst_pkg::FRAME_COUNT; i++) begin
            push_write(i, 16'(10 * i),
                       (i == fst_pkg::FRAME_COUNT - 1) ? NEXT_STOP : 5'(i + 1));
        end
        // zero-duration hops chain into a full-length frame
        push_advance(16'd0);
        push_advance(16'hFFFF);
        // stopped frame clamps at zero
        push_advance(16'hFFFF);
        push_restart();
        push_advance(16'd3);
        push_advance(16'd2);
        push_cmd(CMD_UNUSED, 4'hF, 16'hFFFF, NEXT_STOP, 16'hFFFF);
        // zero-tick self loop hits the hop limit
        push_write(0, 16'd0, 5'd4);
        push_restart();
        push_advance(16'd0);
        push_advance(16'd1);
        // short self loop cannot absorb a large tick count
        push_write(0, 16'd1, 5'd0);
        push_restart();
        push_advance(16'hFFFF);
        push_advance(16'd0);
        push_write(0, 16'd5, 5'd1);
        push_restart();

        while (cmd_queue.size() < ITEM_TARGET) begin
            r = $urandom_range(0, 99);
            if (r < 7) begin
                // ring of short frames entered from frame 0
                k = $urandom_range(1, 6);
                for (int j = 0; j < k; j++) ring[j] = 4'($urandom);
                for (int j = 0; j < k; j++) begin
                    push_write(ring[j],
                               ($urandom_range(0, 2) == 0) ? 16'd0 : 16'($urandom_range(0, 30)),
                               ($urandom_range(0, 7) == 0) ? NEXT_STOP : 5'(ring[(j + 1) % k]));
                end
                push_write(0, 16'($urandom_range(0, 20)), 5'(ring[0]));
                push_restart();
                repeat ($urandom_range(2, 8)) push_advance(draw_ticks());
            end else if (r < 30) begin
                push_write($urandom_range(0, fst_pkg::FRAME_COUNT - 1), draw_dur(), draw_next());
            end else if (r < 85) begin
                push_advance(draw_ticks());
            end else if (r < 97) begin
                push_restart();
            end else begin
                push_cmd(CMD_UNUSED, 4'($urandom), 16'($urandom), 5'($urandom),
                         16'($urandom));
            end
        end

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        while (cmd_queue.size() != 0 || s_tvalid || shown_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (mismatches == 0 && shown_q.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // driver
    int   tx_gap  = 0;
    logic tx_calm = 1'b0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) predict_frame_step(s_tdata);
            if (s_tvalid && !s_tready) begin
                // hold until accepted
            end else if (tx_gap != 0) begin
                s_tvalid <= 1'b0;
                tx_gap   <= tx_gap - 1;
            end else if (cmd_queue.size() != 0) begin
                s_tdata  <= cmd_queue.pop_front();
                s_tvalid <= 1'b1;
                tx_gap   <= tx_calm ? 0 : $urandom_range(0, 12);
                if ($urandom_range(0, 39) == 0) tx_calm <= !tx_calm;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // monitor
    int   rx_wait = 0;
    logic rx_calm = 1'b0;

    always @(posedge aclk) begin
        shown_t want;
        int     stall;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (m_tvalid && m_tready) begin
            if (shown_q.size() == 0) begin
                $display("%0t: unexpected transaction, expected none got %h", $time, m_tdata);
                mismatches++;
            end else begin
                want = shown_q.pop_front();
                if (m_tdata[3:0] !== want.frame) begin
                    $display("%0t: current_frame expected %0d got %0d",
                             $time, want.frame, m_tdata[3:0]);
                    mismatches++;
                end
                if (m_tdata[19:4] !== want.ticks_left) begin
                    $display("%0t: remaining_ticks expected %0d got %0d",
                             $time, want.ticks_left, m_tdata[19:4]);
                    mismatches++;
                end
                if (m_tdata[20] !== want.hit) begin
                    $display("%0t: hop_limit_hit expected %0b got %0b",
                             $time, want.hit, m_tdata[20]);
                    mismatches++;
                end
            end
            stall = rx_calm ? 0 : $urandom_range(0, 12);
            if ($urandom_range(0, 39) == 0) rx_calm <= !rx_calm;
            rx_wait  <= stall;
            m_tready <= (stall == 0);
        end else if (rx_wait != 0) begin
            rx_wait  <= rx_wait - 1;
            m_tready <= (rx_wait == 1);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // watchdog
    int idle_cycles = 0;

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= IDLE_LIMIT) begin
                $display("end of test: mismatches");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

endmodule
